FILE: design/tkee_pkg.sv
// Shared types, key codes, byte constants and tables for the key escape encoder.
// No dependencies; every other design file refers to this package by scoped names.

package tkee_pkg;

  // sequence storage
  localparam int unsigned MAX_SEQ_BYTES = 7;
  localparam int unsigned LEN_W         = $clog2(MAX_SEQ_BYTES + 1);

  // configuration register indexes
  localparam int unsigned CFG_IDX_W  = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_APP_CURSOR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_APP_KEYPAD = 1'b1;

  // virtual key codes
  localparam logic [7:0] KC_BACK     = 8'h08;
  localparam logic [7:0] KC_CLEAR    = 8'h0C;
  localparam logic [7:0] KC_PRIOR    = 8'h21;
  localparam logic [7:0] KC_NEXT     = 8'h22;
  localparam logic [7:0] KC_END      = 8'h23;
  localparam logic [7:0] KC_HOME     = 8'h24;
  localparam logic [7:0] KC_LEFT     = 8'h25;
  localparam logic [7:0] KC_UP       = 8'h26;
  localparam logic [7:0] KC_RIGHT    = 8'h27;
  localparam logic [7:0] KC_DOWN     = 8'h28;
  localparam logic [7:0] KC_INSERT   = 8'h2D;
  localparam logic [7:0] KC_DELETE   = 8'h2E;
  localparam logic [7:0] KC_NUM0     = 8'h60;
  localparam logic [7:0] KC_NUM9     = 8'h69;
  localparam logic [7:0] KC_MULTIPLY = 8'h6A;
  localparam logic [7:0] KC_ADD      = 8'h6B;
  localparam logic [7:0] KC_SUBTRACT = 8'h6D;
  localparam logic [7:0] KC_DECIMAL  = 8'h6E;
  localparam logic [7:0] KC_DIVIDE   = 8'h6F;
  localparam logic [7:0] KC_F1       = 8'h70;
  localparam logic [7:0] KC_F12      = 8'h7B;

  // byte values
  localparam logic [7:0] CH_ESC    = 8'h1B;
  localparam logic [7:0] CH_CTRL_W = 8'h17;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_SS3_O  = 8'h4F;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_TILDE  = 8'h7E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_ONE    = 8'h31;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_DOWN_B = 8'h42;
  localparam logic [7:0] CH_RGHT_C = 8'h43;
  localparam logic [7:0] CH_LEFT_D = 8'h44;
  localparam logic [7:0] CH_END_F  = 8'h46;
  localparam logic [7:0] CH_HOME_H = 8'h48;
  localparam logic [7:0] CH_KP_J   = 8'h6A;
  localparam logic [7:0] CH_KP_K   = 8'h6B;
  localparam logic [7:0] CH_KP_M   = 8'h6D;
  localparam logic [7:0] CH_KP_N   = 8'h6E;
  localparam logic [7:0] CH_KP_O   = 8'h6F;
  localparam logic [7:0] CH_KP_P   = 8'h70;
  localparam logic [7:0] CH_KP_U   = 8'h75;
  localparam logic [7:0] CH_NONE   = 8'h00;

  // one key press beat
  typedef struct packed {
    logic [7:0] vk_code;
    logic       shift_held;
    logic       alt_held;
    logic       ctrl_held;
  } key_beat_t;

  // one output byte beat
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
  } byte_beat_t;

  // a whole encoded sequence, byte 0 goes out first
  typedef struct packed {
    logic [MAX_SEQ_BYTES-1:0][7:0] seq_bytes;
    logic [LEN_W-1:0]              seq_len;
  } seq_t;

  // CSI number of F1..F12 as two BCD digits {tens, ones}
  function automatic logic [7:0] fkey_bcd(logic [3:0] idx);
    logic [7:0] bcd;
    bcd = 8'h00;
    unique case (idx)
      4'd0:    bcd = 8'h11;
      4'd1:    bcd = 8'h12;
      4'd2:    bcd = 8'h13;
      4'd3:    bcd = 8'h14;
      4'd4:    bcd = 8'h15;
      4'd5:    bcd = 8'h17;
      4'd6:    bcd = 8'h18;
      4'd7:    bcd = 8'h19;
      4'd8:    bcd = 8'h20;
      4'd9:    bcd = 8'h21;
      4'd10:   bcd = 8'h23;
      4'd11:   bcd = 8'h24;
      default: bcd = 8'h00;
    endcase
    return bcd;
  endfunction

endpackage

FILE: design/tkee_encode.sv
// Combinational encoder: one registered key press to a full byte sequence.
// Depends on tkee_pkg for key codes, byte constants, the F-key table and seq_t.

module tkee_encode (
  input  tkee_pkg::key_beat_t key_i,
  input  logic                app_cursor_i,
  input  logic                app_keypad_i,
  output tkee_pkg::seq_t      seq_o
);

  typedef enum logic [1:0] {
    FORM_NONE,
    FORM_SS3,
    FORM_CSI,
    FORM_CTRL_W
  } form_e;

  logic [7:0] k;
  logic       mod_none;
  logic [7:0] mod_ch;
  logic [7:0] kp_letter;
  logic [7:0] arrow_letter;
  logic       is_fkey;
  logic [7:0] f_bcd;
  form_e      form;
  logic [7:0] final_ch;
  logic [3:0] num_tens;
  logic [3:0] num_ones;

  function automatic logic [7:0] CH_ONE_SUM(tkee_pkg::key_beat_t kb);
    return tkee_pkg::CH_ONE + {5'b0, kb.ctrl_held, kb.alt_held, kb.shift_held};
  endfunction

  assign k        = key_i.vk_code;
  assign mod_none = !(key_i.shift_held || key_i.alt_held || key_i.ctrl_held);
  // modifier digit is '1' + shift + 2*alt + 4*ctrl
  assign mod_ch   = CH_ONE_SUM(key_i);
  assign is_fkey  = (k >= tkee_pkg::KC_F1) && (k <= tkee_pkg::KC_F12);
  assign f_bcd    = tkee_pkg::fkey_bcd(k[3:0]);

  // application keypad final letter, zero when not a keypad key
  always_comb begin
    kp_letter = tkee_pkg::CH_NONE;
    if ((k >= tkee_pkg::KC_NUM0) && (k <= tkee_pkg::KC_NUM9)) begin
      kp_letter = tkee_pkg::CH_KP_P + {4'b0, k[3:0]};
    end else begin
      unique case (k)
        tkee_pkg::KC_CLEAR:    kp_letter = tkee_pkg::CH_KP_U;
        tkee_pkg::KC_DECIMAL:  kp_letter = tkee_pkg::CH_KP_N;
        tkee_pkg::KC_MULTIPLY: kp_letter = tkee_pkg::CH_KP_J;
        tkee_pkg::KC_ADD:      kp_letter = tkee_pkg::CH_KP_K;
        tkee_pkg::KC_SUBTRACT: kp_letter = tkee_pkg::CH_KP_M;
        tkee_pkg::KC_DIVIDE:   kp_letter = tkee_pkg::CH_KP_O;
        default:               kp_letter = tkee_pkg::CH_NONE;
      endcase
    end
  end

  // arrow final letter, zero when not an arrow
  always_comb begin
    unique case (k)
      tkee_pkg::KC_UP:    arrow_letter = tkee_pkg::CH_UP_A;
      tkee_pkg::KC_DOWN:  arrow_letter = tkee_pkg::CH_DOWN_B;
      tkee_pkg::KC_RIGHT: arrow_letter = tkee_pkg::CH_RGHT_C;
      tkee_pkg::KC_LEFT:  arrow_letter = tkee_pkg::CH_LEFT_D;
      default:            arrow_letter = tkee_pkg::CH_NONE;
    endcase
  end

  // pick the sequence form, its number and final byte
  always_comb begin
    form     = FORM_NONE;
    final_ch = tkee_pkg::CH_NONE;
    num_tens = 4'd0;
    num_ones = 4'd1;
    priority if (app_keypad_i && mod_none && (kp_letter != tkee_pkg::CH_NONE)) begin
      form     = FORM_SS3;
      final_ch = kp_letter;
    end else if (arrow_letter != tkee_pkg::CH_NONE) begin
      form     = (app_cursor_i && mod_none) ? FORM_SS3 : FORM_CSI;
      final_ch = arrow_letter;
    end else if (is_fkey) begin
      form     = FORM_CSI;
      final_ch = tkee_pkg::CH_TILDE;
      num_tens = f_bcd[7:4];
      num_ones = f_bcd[3:0];
    end else begin
      unique case (k)
        tkee_pkg::KC_BACK: begin
          form = key_i.ctrl_held ? FORM_CTRL_W : FORM_NONE;
        end
        tkee_pkg::KC_HOME: begin
          form     = FORM_CSI;
          final_ch = tkee_pkg::CH_HOME_H;
        end
        tkee_pkg::KC_END: begin
          form     = FORM_CSI;
          final_ch = tkee_pkg::CH_END_F;
        end
        tkee_pkg::KC_INSERT: begin
          form     = FORM_CSI;
          final_ch = tkee_pkg::CH_TILDE;
          num_ones = 4'd2;
        end
        tkee_pkg::KC_DELETE: begin
          form     = FORM_CSI;
          final_ch = tkee_pkg::CH_TILDE;
          num_ones = 4'd3;
        end
        tkee_pkg::KC_PRIOR: begin
          form     = FORM_CSI;
          final_ch = tkee_pkg::CH_TILDE;
          num_ones = 4'd5;
        end
        tkee_pkg::KC_NEXT: begin
          form     = FORM_CSI;
          final_ch = tkee_pkg::CH_TILDE;
          num_ones = 4'd6;
        end
        default: begin
          form = FORM_NONE;
        end
      endcase
    end
  end

  // lay the bytes out in order
  always_comb begin
    logic [tkee_pkg::LEN_W-1:0] pos;
    seq_o = '0;
    pos   = '0;
    unique case (form)
      FORM_SS3: begin
        seq_o.seq_bytes[0] = tkee_pkg::CH_ESC;
        seq_o.seq_bytes[1] = tkee_pkg::CH_SS3_O;
        seq_o.seq_bytes[2] = final_ch;
        seq_o.seq_len      = tkee_pkg::LEN_W'(3);
      end
      FORM_CSI: begin
        seq_o.seq_bytes[0] = tkee_pkg::CH_ESC;
        seq_o.seq_bytes[1] = tkee_pkg::CH_LBRACK;
        pos = tkee_pkg::LEN_W'(2);
        if (num_tens != 4'd0) begin
          seq_o.seq_bytes[pos] = tkee_pkg::CH_ZERO + {4'b0, num_tens};
          pos = pos + tkee_pkg::LEN_W'(1);
        end
        seq_o.seq_bytes[pos] = tkee_pkg::CH_ZERO + {4'b0, num_ones};
        pos = pos + tkee_pkg::LEN_W'(1);
        if (!mod_none) begin
          seq_o.seq_bytes[pos] = tkee_pkg::CH_SEMI;
          pos = pos + tkee_pkg::LEN_W'(1);
          seq_o.seq_bytes[pos] = mod_ch;
          pos = pos + tkee_pkg::LEN_W'(1);
        end
        seq_o.seq_bytes[pos] = final_ch;
        seq_o.seq_len        = pos + tkee_pkg::LEN_W'(1);
      end
      FORM_CTRL_W: begin
        if (key_i.alt_held) begin
          seq_o.seq_bytes[0] = tkee_pkg::CH_ESC;
          seq_o.seq_bytes[1] = tkee_pkg::CH_CTRL_W;
          seq_o.seq_len      = tkee_pkg::LEN_W'(2);
        end else begin
          seq_o.seq_bytes[0] = tkee_pkg::CH_CTRL_W;
          seq_o.seq_len      = tkee_pkg::LEN_W'(1);
        end
      end
      default: begin
        seq_o.seq_len = '0;
      end
    endcase
  end

endmodule

FILE: design/tkee_serializer.sv
// Sequence buffer and byte shifter: sends a loaded sequence one byte per cycle.
// Depends on tkee_pkg for seq_t, byte_beat_t and the sequence sizes.

module tkee_serializer (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  tkee_pkg::seq_t       seq_i,
  output logic                 free_o,
  output logic                 byte_valid_o,
  output tkee_pkg::byte_beat_t byte_o
);

  logic [tkee_pkg::MAX_SEQ_BYTES-1:0][7:0] buf_q, buf_d;
  logic [tkee_pkg::LEN_W-1:0]              remain_q, remain_d;

  // free for a new sequence once the current last byte is going out
  assign free_o       = (remain_q <= tkee_pkg::LEN_W'(1));
  assign byte_valid_o = (remain_q != '0);
  assign byte_o.out_byte  = buf_q[0];
  assign byte_o.last_byte = (remain_q == tkee_pkg::LEN_W'(1));

  // load or shift toward byte 0
  always_comb begin
    buf_d    = buf_q;
    remain_d = remain_q;
    if (load_i) begin
      buf_d    = seq_i.seq_bytes;
      remain_d = seq_i.seq_len;
    end else if (remain_q != '0) begin
      buf_d    = {8'h00, buf_q[tkee_pkg::MAX_SEQ_BYTES-1:1]};
      remain_d = remain_q - tkee_pkg::LEN_W'(1);
    end
  end

  // byte count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      remain_q <= '0;
    end else begin
      remain_q <= remain_d;
    end
  end

  // sequence bytes, payload only
  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

endmodule

FILE: design/terminal_key_escape_encoder_unit.sv
// Top level of the key escape encoder: key register, mode registers, encoder, shifter.
// Depends on tkee_pkg, tkee_encode and tkee_serializer.
//
//  channel   | ports                                  | handshake
//  ----------+----------------------------------------+------------------------------
//  key in    | start, busy, key_i                     | taken when start && !busy
//  byte out  | result_valid_o, result_o               | valid per byte, no stall
//  config    | cfg_we_i, cfg_idx_i, cfg_wdata_i       | written when cfg_we_i is high
//
// A key beat waits in the key register until the shifter is free, is encoded and loaded
// into the shifter, and its bytes leave from the cycle after the load on, one per cycle (0 to 7 bytes).
// A key in the key register moves on as the last byte of the key ahead goes out, or at once
// when the shifter is empty; a new key is taken only when the key register is empty or its key moves on.
// busy is high only while a key waits in the key register for the shifter to drain.
// Reset empties the key register and the shifter and clears both mode bits; the
// receiver cannot stall.

module terminal_key_escape_encoder_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  tkee_pkg::key_beat_t                 key_i,
  output logic                                result_valid_o,
  output tkee_pkg::byte_beat_t                result_o,
  input  logic                                cfg_we_i,
  input  logic [tkee_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic                                cfg_wdata_i
);

  logic                app_cursor_q, app_keypad_q;
  logic                key_vld_q, key_vld_d;
  tkee_pkg::key_beat_t key_q;
  tkee_pkg::seq_t      seq;
  logic                ser_free;
  logic                move;
  logic                accept;

  // handoff from key register into the shifter
  assign move      = key_vld_q && ser_free;
  assign busy      = key_vld_q && !ser_free;
  assign accept    = start && !busy;
  assign key_vld_d = accept || (key_vld_q && !move);

  // mode registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      app_cursor_q <= 1'b0;
      app_keypad_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tkee_pkg::CFG_APP_CURSOR: app_cursor_q <= cfg_wdata_i;
        tkee_pkg::CFG_APP_KEYPAD: app_keypad_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // key register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_vld_q <= 1'b0;
    end else begin
      key_vld_q <= key_vld_d;
    end
  end

  // key register payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_q <= key_i;
    end
  end

  tkee_encode u_encode (
    .key_i        (key_q),
    .app_cursor_i (app_cursor_q),
    .app_keypad_i (app_keypad_q),
    .seq_o        (seq)
  );

  tkee_serializer u_serializer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (move),
    .seq_i        (seq),
    .free_o       (ser_free),
    .byte_valid_o (result_valid_o),
    .byte_o       (result_o)
  );

endmodule
